>>> hw/rtl/tcwc_pkg.sv
// tcwc_pkg: shared types, register map, command codes and reset values for
// the congestion window block. No dependencies.
package tcwc_pkg;

    // Default fraction width of window and threshold (Q8.FRACTION_BITS)
    localparam int FRACTION_BITS_DEF = 16;

    // Event codes
    localparam logic [1:0] CMD_SEND    = 2'd0;
    localparam logic [1:0] CMD_ACK     = 2'd1;
    localparam logic [1:0] CMD_ROUND   = 2'd2;
    localparam logic [1:0] CMD_TIMEOUT = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SEG_SIZE   = 3'd0;
    localparam logic [2:0] REG_START_SEQ  = 3'd1;
    localparam logic [2:0] REG_INIT_THR   = 3'd2;
    localparam logic [2:0] REG_TOTAL_LEN  = 3'd3;
    localparam logic [2:0] REG_DUP_LIMIT  = 3'd4;

    // Register reset values
    localparam logic [3:0]  RST_SEG_SIZE  = 4'd2;
    localparam logic [15:0] RST_START_SEQ = 16'd257;
    localparam logic [7:0]  RST_INIT_THR  = 8'd16;
    localparam logic [15:0] RST_TOTAL_LEN = 16'd0;
    localparam logic [3:0]  RST_DUP_LIMIT = 4'd3;

    localparam logic [7:0]  DUP_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] ack_number;
    } t_in_item;

    typedef struct packed {
        logic [15:0] segment_sequence;
        logic [23:0] window_value;
        logic [23:0] threshold_value;
        logic [8:0]  window_segments;
        logic        round_complete;
        logic        reduced;
        logic        finished;
    } t_out_item;

    // Register write request from the bus port
    typedef struct packed {
        logic        en;
        logic [2:0]  idx;
        logic [31:0] data;
    } t_cfg_wr;

    // Register contents for readback
    typedef struct packed {
        logic [3:0]  seg_size;
        logic [15:0] start_seq;
        logic [7:0]  init_thr;
        logic [15:0] total_len;
        logic [3:0]  dup_limit;
    } t_cfg_regs;

    // Controller -> datapath
    typedef struct packed {
        logic capture;
        logic div_init;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_dp_stat;

endpackage

>>> hw/rtl/tcwc_ctrl.sv
// tcwc_ctrl: sequencing state machine and output-valid flag.
// Depends on tcwc_pkg.
module tcwc_ctrl
    import tcwc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_WRITE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.need_div) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_WRITE: begin
                // result slot free or draining this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> hw/rtl/tcwc_dpath.sv
// tcwc_dpath: config registers, connection state, restoring reciprocal
// divider and result register. Depends on tcwc_pkg.
module tcwc_dpath
    import tcwc_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_cfg_wr   i_cfg_wr,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_cfg_regs o_cfg_regs,
    output t_out_item o_out_data
);

    localparam int WB = 8 + FRACTION_BITS;
    localparam int QW = FRACTION_BITS + 1;
    localparam int CW = $clog2(FRACTION_BITS + 2);
    localparam logic [WB-1:0] WinOne = WB'(1) << FRACTION_BITS;
    localparam logic [WB-1:0] WinMax = '1;

    function automatic logic [WB-1:0] sat_add(input logic [WB-1:0] a,
                                              input logic [WB-1:0] b);
        logic [WB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WB] ? WinMax : s[WB-1:0];
    endfunction

    // config
    logic [3:0]  r_seg_size;
    logic [15:0] r_start_seq;
    logic [7:0]  r_init_thr;
    logic [15:0] r_total_len;
    logic [3:0]  r_dup_limit;

    // connection state
    logic [15:0]   r_next_seq, n_next_seq;
    logic [WB-1:0] r_window,   n_window;
    logic [WB-1:0] r_thresh,   n_thresh;
    logic [15:0]   r_prev_ack, n_prev_ack;
    logic [7:0]    r_dup_cnt,  n_dup_cnt;
    logic [15:0]   r_lowest,   n_lowest;
    logic [15:0]   r_highest,  n_highest;

    // captured event
    logic [1:0]  r_cmd;
    logic [15:0] r_ack;

    // divider
    logic [7:0]    r_rem;
    logic [QW-1:0] r_quo;
    logic [7:0]    r_dvs;
    logic [CW-1:0] r_div_cnt;
    logic [8:0]    rem_sh;
    logic          q_bit;
    logic [7:0]    whole;

    logic          below;
    logic          fin_now;
    logic          fin_next;
    logic          sent;
    logic          cut;
    logic          do_reduce;
    logic [WB-1:0] half;
    logic [WB-1:0] red_thr;
    logic [WB-1:0] win_grown;
    logic [WB:0]   win_ceil;
    t_out_item     n_out;
    t_out_item     r_out;

    assign below   = r_window < r_thresh;
    assign fin_now = (r_next_seq - r_start_seq) >= r_total_len;
    assign half    = r_window >> 1;
    assign red_thr = (half > WinOne) ? half : WinOne;
    assign whole   = r_window[WB-1:FRACTION_BITS];

    assign win_grown = sat_add(r_window, below ? WinOne : WB'(r_quo));

    assign o_stat.need_div = (r_cmd == CMD_ACK) && (r_ack != r_prev_ack) && !below;
    assign o_stat.div_done = (r_div_cnt == '0);

    // one restoring step: shift in next dividend bit from quotient MSB
    assign rem_sh = {r_rem, r_quo[QW-1]};
    assign q_bit  = rem_sh >= {1'b0, r_dvs};

    always_comb begin
        n_next_seq = r_next_seq;
        n_window   = r_window;
        n_thresh   = r_thresh;
        n_prev_ack = r_prev_ack;
        n_dup_cnt  = r_dup_cnt;
        n_lowest   = r_lowest;
        n_highest  = r_highest;
        sent       = 1'b0;
        cut        = 1'b0;
        do_reduce  = 1'b0;
        unique case (r_cmd)
            CMD_SEND: begin
                if (!fin_now) begin
                    sent       = 1'b1;
                    n_highest  = r_next_seq;
                    n_next_seq = r_next_seq + 16'(r_seg_size);
                end
            end
            CMD_ACK: begin
                if (r_ack == r_prev_ack) begin
                    if (r_dup_cnt != DUP_MAX) begin
                        n_dup_cnt = r_dup_cnt + 8'd1;
                    end
                end else begin
                    n_dup_cnt = '0;
                    n_window  = win_grown;
                    n_lowest  = r_ack;
                end
                n_prev_ack = r_ack;
            end
            CMD_ROUND: begin
                do_reduce = r_dup_cnt >= 8'(r_dup_limit);
            end
            CMD_TIMEOUT: begin
                do_reduce = 1'b1;
            end
        endcase
        if (do_reduce) begin
            n_thresh   = red_thr;
            n_window   = WinOne;
            n_next_seq = r_lowest;
            cut        = 1'b1;
        end
    end

    assign fin_next = (n_next_seq - r_start_seq) >= r_total_len;
    assign win_ceil = {1'b0, n_window} + {1'b0, WinOne - WB'(1)};

    always_comb begin
        n_out.segment_sequence = sent ? r_next_seq : n_next_seq;
        n_out.window_value     = 24'(n_window);
        n_out.threshold_value  = 24'(n_thresh);
        n_out.window_segments  = win_ceil[WB:FRACTION_BITS];
        n_out.round_complete   = n_lowest > n_highest;
        n_out.reduced          = cut;
        n_out.finished         = fin_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_size  <= RST_SEG_SIZE;
            r_start_seq <= RST_START_SEQ;
            r_init_thr  <= RST_INIT_THR;
            r_total_len <= RST_TOTAL_LEN;
            r_dup_limit <= RST_DUP_LIMIT;
            r_next_seq  <= RST_START_SEQ;
            r_window    <= WinOne;
            r_thresh    <= WB'(RST_INIT_THR) << FRACTION_BITS;
            r_prev_ack  <= '0;
            r_dup_cnt   <= '0;
            r_lowest    <= RST_START_SEQ;
            r_highest   <= '0;
            r_div_cnt   <= '0;
        end else begin
            if (i_cfg_wr.en) begin
                unique case (i_cfg_wr.idx)
                    REG_SEG_SIZE:  r_seg_size <= i_cfg_wr.data[3:0];
                    REG_START_SEQ: begin
                        r_start_seq <= i_cfg_wr.data[15:0];
                        r_next_seq  <= i_cfg_wr.data[15:0];
                        r_lowest    <= i_cfg_wr.data[15:0];
                    end
                    REG_INIT_THR: begin
                        r_init_thr <= i_cfg_wr.data[7:0];
                        r_thresh   <= WB'(i_cfg_wr.data[7:0]) << FRACTION_BITS;
                    end
                    REG_TOTAL_LEN: r_total_len <= i_cfg_wr.data[15:0];
                    REG_DUP_LIMIT: r_dup_limit <= i_cfg_wr.data[3:0];
                    default: ;
                endcase
            end else if (i_cmd.commit) begin
                r_next_seq <= n_next_seq;
                r_window   <= n_window;
                r_thresh   <= n_thresh;
                r_prev_ack <= n_prev_ack;
                r_dup_cnt  <= n_dup_cnt;
                r_lowest   <= n_lowest;
                r_highest  <= n_highest;
            end
            if (i_cmd.div_init) begin
                r_div_cnt <= CW'(QW);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - CW'(1);
            end
        end
    end

    // payload, divider and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_in_data.command;
            r_ack <= i_in_data.ack_number;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= QW'(1) << FRACTION_BITS;
            r_dvs <= (whole == '0) ? 8'd1 : whole;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? 8'(rem_sh - {1'b0, r_dvs}) : rem_sh[7:0];
            r_quo <= {r_quo[QW-2:0], q_bit};
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    assign o_cfg_regs.seg_size  = r_seg_size;
    assign o_cfg_regs.start_seq = r_start_seq;
    assign o_cfg_regs.init_thr  = r_init_thr;
    assign o_cfg_regs.total_len = r_total_len;
    assign o_cfg_regs.dup_limit = r_dup_limit;

endmodule

>>> hw/rtl/tcp_congestion_window_control.sv
// tcp_congestion_window_control: top level, bus register port, controller
// and datapath. Depends on tcwc_pkg, tcwc_ctrl, tcwc_dpath.
//
// Channel   Direction  Handshake                         Payload
// event     in         i_in_valid / o_in_ready           i_in_data  (t_in_item)
// result    out        o_out_valid / i_out_ready         o_out_data (t_out_item)
// config    in         psel, penable, pwrite, pready     paddr, pwdata / prdata
//
// An event goes through capture, evaluate and write; the write loads the output register.
// A fresh ack in congestion avoidance adds a divide between evaluate and write: FRACTION_BITS+1
// divider steps, then a done check. Window and threshold are Q8.16 by default.
// Next event is taken once the result is written to the output register,
// even while that result still waits; a stalled output holds the write step.
// Synchronous active-low reset loads defaults and connection state.
module tcp_congestion_window_control
    import tcwc_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_dp_cmd   dp_cmd;
    t_dp_stat  dp_stat;
    t_cfg_wr   cfg_wr;
    t_cfg_regs cfg_regs;

    // Register write lands in the access phase
    assign pready      = 1'b1;
    assign cfg_wr.en   = psel && penable && pwrite && pready;
    assign cfg_wr.idx  = paddr[4:2];
    assign cfg_wr.data = pwdata;

    // Readback, zero-extended; unmapped addresses read zero
    always_comb begin
        unique case (paddr[4:2])
            REG_SEG_SIZE:  prdata = 32'(cfg_regs.seg_size);
            REG_START_SEQ: prdata = 32'(cfg_regs.start_seq);
            REG_INIT_THR:  prdata = 32'(cfg_regs.init_thr);
            REG_TOTAL_LEN: prdata = 32'(cfg_regs.total_len);
            REG_DUP_LIMIT: prdata = 32'(cfg_regs.dup_limit);
            default:       prdata = '0;
        endcase
    end

    tcwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    tcwc_dpath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg_wr   (cfg_wr),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .o_cfg_regs (cfg_regs),
        .o_out_data (o_out_data)
    );

`ifndef SYNTHESIS
    // One event in flight: no second transfer right after a capture
    a_single_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("event taken while previous one in flight");

    // A fresh result only follows a commit
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(dp_cmd.commit))
        else $error("result valid without commit");

    // Divider never stepped past its last bit
    a_div_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.div_step |-> !dp_stat.div_done)
        else $error("divider stepped after completion");

    // Window never drops below one segment
    a_window_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.window_segments != 9'd0))
        else $error("window below one segment");
`endif

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for tcp_congestion_window_control. Drives
// events and register writes, predicts each result and checks every transfer.
// Depends on tcwc_pkg and the tcp_congestion_window_control RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tcwc_pkg::*;

    localparam int          FRAC          = FRACTION_BITS_DEF;
    localparam logic [23:0] WIN_ONE       = 24'(1) << FRAC;   // 1.0 in Q8.FRAC
    localparam logic [23:0] WIN_FULL      = '1;               // saturation value
    localparam int          REPORT_CAP    = 60;       // keep the log short on a bad run
    localparam int          SETTLE_CYCLES = 30;       // divider plus pipeline, with margin
    localparam int          CYCLE_LIMIT   = 400_000;
    localparam int          MIX_PHASES    = 6;
    localparam int          MIX_ITEMS     = 40;
    localparam int          CLIMB_ACKS    = 515;      // slow start to 255.0, then saturate
    localparam int          DUP_FLOOD     = 258;      // past the 8-bit duplicate counter top

    // Tracks the sender state the block should hold and queues the result
    // each accepted event must produce.
    class cwnd_tracker;
        logic [3:0]  seg_size;
        logic [15:0] start_seq;
        logic [7:0]  init_thr;
        logic [15:0] total_len;
        logic [3:0]  dup_limit;
        logic [15:0] next_seq;
        logic [23:0] cwnd;
        logic [23:0] ssthresh;
        logic [15:0] recent_ack;
        logic [7:0]  dup_cnt;
        logic [15:0] low_acked;
        logic [15:0] high_sent;
        t_out_item   reports_due[$];
        int          errors;

        function new();
            errors     = 0;
            seg_size   = RST_SEG_SIZE;
            start_seq  = RST_START_SEQ;
            init_thr   = RST_INIT_THR;
            total_len  = RST_TOTAL_LEN;
            dup_limit  = RST_DUP_LIMIT;
            next_seq   = RST_START_SEQ;
            cwnd       = WIN_ONE;
            ssthresh   = 24'(RST_INIT_THR) << FRAC;
            recent_ack = '0;
            dup_cnt    = '0;
            low_acked  = RST_START_SEQ;
            high_sent  = '0;
        endfunction

        function void load_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_SEG_SIZE:  seg_size = value[3:0];
                REG_START_SEQ: begin
                    start_seq = value[15:0];
                    next_seq  = value[15:0];
                    low_acked = value[15:0];
                end
                REG_INIT_THR: begin
                    init_thr = value[7:0];
                    ssthresh = 24'(value[7:0]) << FRAC;
                end
                REG_TOTAL_LEN: total_len = value[15:0];
                REG_DUP_LIMIT: dup_limit = value[3:0];
                default: ;
            endcase
        endfunction

        // All bytes sent once the offset from the start (mod 2^16) reaches the length
        function bit all_sent();
            logic [15:0] offset;
            offset = next_seq - start_seq;
            return offset >= total_len;
        endfunction

        function void note_event(t_in_item ev);
            t_out_item   want;
            logic [15:0] shown;
            logic [23:0] whole;
            logic [24:0] grown;
            logic [24:0] rounded;
            bit          cut;
            shown = next_seq;
            cut   = 1'b0;
            case (ev.command)
                CMD_SEND: begin
                    if (!all_sent()) begin
                        high_sent = next_seq;
                        next_seq  = next_seq + 16'(seg_size);
                    end
                end
                CMD_ACK: begin
                    if (ev.ack_number == recent_ack) begin
                        if (dup_cnt != DUP_MAX) begin
                            dup_cnt++;
                        end
                    end else begin
                        dup_cnt = '0;
                        if (cwnd < ssthresh) begin
                            grown = {1'b0, cwnd} + WIN_ONE;
                        end else begin
                            whole = cwnd >> FRAC;
                            if (whole == '0) begin
                                whole = 24'd1;
                            end
                            grown = {1'b0, cwnd} + 25'(WIN_ONE / whole);
                        end
                        cwnd      = grown[24] ? WIN_FULL : grown[23:0];
                        low_acked = ev.ack_number;
                    end
                    recent_ack = ev.ack_number;
                end
                CMD_ROUND: cut = (dup_cnt >= 8'(dup_limit));
                default:   cut = 1'b1;
            endcase
            if (cut) begin
                ssthresh = (cwnd >> 1) > WIN_ONE ? (cwnd >> 1) : WIN_ONE;
                cwnd     = WIN_ONE;
                next_seq = low_acked;
            end
            if (ev.command != CMD_SEND) begin
                shown = next_seq;
            end
            rounded = {1'b0, cwnd} + 25'(WIN_ONE - 24'd1);
            want.segment_sequence = shown;
            want.window_value     = cwnd;
            want.threshold_value  = ssthresh;
            want.window_segments  = 9'(rounded >> FRAC);
            want.round_complete   = low_acked > high_sent;
            want.reduced          = cut;
            want.finished         = all_sent();
            reports_due.push_back(want);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t: %s expected %0h got %0h", $time, field, want, got);
                end
            end
        endfunction

        function void check_report(t_out_item got);
            t_out_item want;
            if (reports_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    $display("%0t: result transfer with nothing pending, got %h",
                             $time, got);
                end
                return;
            end
            want = reports_due.pop_front();
            compare_field("segment_sequence", want.segment_sequence, got.segment_sequence);
            compare_field("window_value", want.window_value, got.window_value);
            compare_field("threshold_value", want.threshold_value, got.threshold_value);
            compare_field("window_segments", want.window_segments, got.window_segments);
            compare_field("round_complete", want.round_complete, got.round_complete);
            compare_field("reduced", want.reduced, got.reduced);
            compare_field("finished", want.finished, got.finished);
        endfunction
    endclass

    // Clock, reset and every block input start at a known value
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_item    in_data   = '0;
    logic        out_ready = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [4:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic [31:0] prdata;
    logic        pready;

    cwnd_tracker tracker;
    int          in_quiet  = 0;    // remaining items of a no-gap stretch, event side
    int          out_quiet = 0;    // same for the result side

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    tcp_congestion_window_control i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Random per-item wait; now and then a stretch with no waits at all
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet = $urandom_range(10, 40);
        end
        return $urandom_range(0, 5);
    endfunction

    // Register value for a random phase: forced low or high on request, plus
    // random junk above the register width that the block must drop.
    function automatic logic [31:0] pick_value(bit at_lo, bit at_hi, int width,
                                               int unsigned lo, int unsigned hi);
        logic [31:0] value;
        value = at_lo ? lo : at_hi ? hi : $urandom_range(lo, hi);
        return ($urandom << width) | value;
    endfunction

    // Bus write: setup cycle, then access until pready; the register takes the
    // value at that edge, so the tracker is updated there too. Called at a
    // falling edge, returns at a falling edge with the bus idle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.load_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // One event transfer. Valid stays up between back-to-back items, so it is
    // only dropped when a gap is drawn.
    task automatic send_event(input logic [1:0] cmd, input logic [15:0] ack);
        t_in_item ev;
        int       gap;
        ev.command    = cmd;
        ev.ack_number = ack;
        gap = draw_wait(in_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (!o_in_ready);
        tracker.note_event(ev);
        @(negedge clk);
    endtask

    // Drain: stop sending, wait for every pending result, then give the block
    // time to finish any divide before the next register write.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.reports_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Result side: random stall before each transfer, check at the accepting edge
    initial begin : result_sink
        int stall;
        wait (rst_n);
        @(negedge clk);
        forever begin
            stall = draw_wait(out_quiet);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!o_out_valid);
            tracker.check_report(o_out_data);
            @(negedge clk);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        int          r;
        logic [1:0]  cmd;
        logic [15:0] ack;
        tracker = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: start near the top of the sequence space so six 2-byte
        // sends wrap past zero and reach the 12-byte total; the seventh send
        // finds the transfer done. Threshold 2 puts the second ack into
        // congestion avoidance (+1/floor(window)).
        write_reg(REG_TOTAL_LEN, 32'd12);
        write_reg(REG_START_SEQ, 32'd65530);
        write_reg(REG_INIT_THR, 32'd2);
        write_reg(3'(REG_DUP_LIMIT + 1), $urandom);      // unmapped, no effect
        repeat (7) send_event(CMD_SEND, 16'($urandom));
        send_event(CMD_ACK, 16'd65532);                  // slow start
        send_event(CMD_ACK, 16'd65534);                  // avoidance, +0.5
        send_event(CMD_ACK, 16'd0);
        send_event(CMD_ACK, 16'd0);                      // duplicates
        send_event(CMD_ACK, 16'd0);
        send_event(CMD_ROUND, 16'($urandom));            // two dups: below limit
        send_event(CMD_ACK, 16'd0);
        send_event(CMD_ROUND, 16'($urandom));            // three dups: cut, rewind
        send_event(CMD_SEND, 16'($urandom));
        send_event(CMD_ACK, 16'hFFFF);
        send_event(CMD_TIMEOUT, 16'($urandom));          // half of 2.0 sits on the 1.0 floor
        send_event(CMD_ROUND, 16'($urandom));
        send_event(CMD_ACK, 16'hFFFF);

        // Random phases. Each sets all registers, forcing the extremes in the
        // first phases, then runs mostly plausible traffic: sends, acks that
        // repeat the last one or move forward by whole segments, round ends
        // and a few timeouts, with some acks of arbitrary value as noise.
        for (int p = 0; p < MIX_PHASES; p++) begin
            settle();
            write_reg(REG_SEG_SIZE, pick_value(p == 0, p == 1, 4, 0, 15));
            write_reg(REG_START_SEQ, pick_value(p == 2, p == 3, 16, 0, 16'hFFFF));
            write_reg(REG_INIT_THR, pick_value(p == 0, p == 1, 8, 0, 255));
            write_reg(REG_TOTAL_LEN, pick_value(p == 1, p == 2, 16, 0,
                                                p == 2 ? 16'hFFFF : 120));
            write_reg(REG_DUP_LIMIT, pick_value(p == 0, p == 1, 4, 0, 15));
            write_reg(3'(REG_DUP_LIMIT + $urandom_range(1, 3)), $urandom);
            for (int n = 0; n < MIX_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                cmd = r < 40 ? CMD_SEND : r < 75 ? CMD_ACK : r < 92 ? CMD_ROUND : CMD_TIMEOUT;
                r = $urandom_range(0, 99);
                if (cmd != CMD_ACK || r >= 90) begin
                    ack = 16'($urandom);
                end else if (r < 45) begin
                    ack = tracker.recent_ack;
                end else begin
                    ack = tracker.low_acked + 16'(tracker.seg_size * $urandom_range(1, 4));
                end
                send_event(cmd, ack);
            end
        end

        // Window climb: from 1.0 with threshold 255, a long run of fresh acks
        // goes through slow start, then avoidance at +1/255, and pins the
        // window at the all-ones value. The timeout then halves a full window.
        settle();
        send_event(CMD_TIMEOUT, 16'($urandom));
        settle();
        write_reg(REG_INIT_THR, 32'd255);
        repeat (CLIMB_ACKS) begin
            send_event(CMD_ACK, tracker.recent_ack + 16'($urandom_range(1, 300)));
        end
        send_event(CMD_SEND, 16'($urandom));
        send_event(CMD_ROUND, 16'($urandom));
        send_event(CMD_TIMEOUT, 16'($urandom));

        // Duplicate flood: the count must stick at its top, so a round end
        // with the highest limit still cuts after more than 255 repeats.
        settle();
        write_reg(REG_DUP_LIMIT, 32'd15);
        send_event(CMD_ACK, tracker.recent_ack + 16'd1);
        repeat (DUP_FLOOD) send_event(CMD_ACK, tracker.recent_ack);
        send_event(CMD_ROUND, 16'($urandom));

        settle();
        if (tracker.errors == 0 && tracker.reports_due.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
